// ===== hw/rtl/vlce_pkg.sv =====
package vlce_pkg;

  localparam int VECTOR_BITS = 128;
  localparam int HALF_BITS   = VECTOR_BITS / 2;
  localparam int NUM_BYTES   = VECTOR_BITS / 8;
  localparam int MASK_BITS   = 16;
  localparam int BYTE_IDX_W  = $clog2(NUM_BYTES);

  typedef enum logic [0:0] {
    FUNC_COMPRESS = 1'b0,
    FUNC_EXPAND   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    FW_8  = 2'd0,
    FW_16 = 2'd1,
    FW_32 = 2'd2,
    FW_64 = 2'd3
  } field_width_t;

  typedef struct packed {
    func_t                func;
    field_width_t         field_width_code;
    logic [HALF_BITS-1:0] data_lo;
    logic [HALF_BITS-1:0] data_hi;
    logic [MASK_BITS-1:0] lane_mask;
  } src_item_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] result_lo;
    logic [HALF_BITS-1:0] result_hi;
  } res_item_t;

  // byte-granular view of the field selection
  typedef struct packed {
    logic [NUM_BYTES-1:0]                 sel;
    logic [NUM_BYTES-1:0][BYTE_IDX_W-1:0] rank;
  } lane_map_t;

endpackage

// ===== hw/rtl/vlce_lane_map.sv =====
module vlce_lane_map
  import vlce_pkg::*;
(
  input  field_width_t         field_width_code,
  input  logic [MASK_BITS-1:0] lane_mask,
  output lane_map_t            lane_map
);

  logic [NUM_BYTES-1:0] sel;
  logic [NUM_BYTES-1:0] below;

  // byte k belongs to field k >> code; high mask bits fall away naturally
  always_comb begin
    for (int k = 0; k < NUM_BYTES; k++) begin
      sel[k] = lane_mask[BYTE_IDX_W'(k) >> field_width_code];
    end
  end

  // rank of a byte: selected bytes strictly below it
  always_comb begin
    below = '0;
    for (int k = 0; k < NUM_BYTES; k++) begin
      below            = (NUM_BYTES'(1) << k) - NUM_BYTES'(1);
      lane_map.rank[k] = BYTE_IDX_W'($countones(sel & below));
    end
    lane_map.sel = sel;
  end

endmodule

// ===== hw/rtl/vlce_permute.sv =====
module vlce_permute
  import vlce_pkg::*;
(
  input  func_t                func,
  input  logic [HALF_BITS-1:0] data_lo,
  input  logic [HALF_BITS-1:0] data_hi,
  input  lane_map_t            lane_map,
  output res_item_t            result
);

  logic [NUM_BYTES-1:0][7:0] src_bytes;
  logic [NUM_BYTES-1:0][7:0] cmp_bytes;
  logic [NUM_BYTES-1:0][7:0] exp_bytes;
  logic [NUM_BYTES-1:0][7:0] res_bytes;

  assign src_bytes = {data_hi, data_lo};

  // compress: output byte i gathers the selected byte of rank i
  always_comb begin
    cmp_bytes = '0;
    for (int i = 0; i < NUM_BYTES; i++) begin
      for (int k = 0; k < NUM_BYTES; k++) begin
        if (lane_map.sel[k] && (lane_map.rank[k] == BYTE_IDX_W'(i))) begin
          cmp_bytes[i] = cmp_bytes[i] | src_bytes[k];
        end
      end
    end
  end

  // expand: selected byte k takes source byte of its rank
  always_comb begin
    for (int k = 0; k < NUM_BYTES; k++) begin
      exp_bytes[k] = lane_map.sel[k] ? src_bytes[lane_map.rank[k]] : 8'h00;
    end
  end

  always_comb begin
    case (func)
      FUNC_COMPRESS: res_bytes = cmp_bytes;
      FUNC_EXPAND:   res_bytes = exp_bytes;
      default:       res_bytes = '0;
    endcase
  end

  assign {result.result_hi, result.result_lo} = res_bytes;

endmodule

// ===== hw/rtl/vector_lane_compress_expand.sv =====
// Lane compress / expand on a 128-bit vector cut into fields of 8, 16, 32 or
// 64 bits, with the lane mask trimmed to the field count. One result item per
// input item, and a new item is taken every cycle: the item sits in an input
// register, the byte-rank and byte-crossbar logic between the input and output
// registers is combinational, and the result lands in an output register.
// Throughput drops only while the output register is stalled by the consumer.
// No state survives an item; reset only clears the valid flags.
module vector_lane_compress_expand
  import vlce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  src_item_t src_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  // input stage
  logic      s1_valid;
  src_item_t s1_item;

  // combinational datapath
  lane_map_t lane_map;
  res_item_t res_next;

  // handshake glue
  logic res_load_ok;
  logic s1_advance;

  // output register can take a new item when empty or being drained
  assign res_load_ok = !res_valid || res_ready;
  assign s1_advance  = s1_valid && res_load_ok;
  assign src_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      s1_item <= src_item;
    end
  end

  // byte select and rank from width code and mask
  vlce_lane_map u_lane_map (
    .field_width_code (s1_item.field_width_code),
    .lane_mask        (s1_item.lane_mask),
    .lane_map         (lane_map)
  );

  // byte crossbar for compress and expand
  vlce_permute u_permute (
    .func     (s1_item.func),
    .data_lo  (s1_item.data_lo),
    .data_hi  (s1_item.data_hi),
    .lane_map (lane_map),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load_ok) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_item <= res_next;
    end
  end

  // input side stalls only when both stages are full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (s1_valid && res_valid && !res_ready))
    else $error("input stalled without a full pipeline");

  // a new result only appears from an occupied input stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid))
    else $error("result valid without an item in the input stage");

  // reset empties both stages
  assert property (@(posedge clk)
    rst |=> (!res_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/vector_lane_compress_expand_tb.sv =====
`timescale 1ns / 1ps

module vector_lane_compress_expand_tb;
  import vlce_pkg::*;

  // run limit in cycles, far above the slowest legal run of ~1300 items
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  src_item_t src_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res_item;

  // results still owed by the block, oldest first
  res_item_t lane_result_q[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  compress_sent = 0;
  int  expand_sent = 0;
  int  width_sent[4] = '{0, 0, 0, 0};
  int  cycle_count = 0;
  // when set, neither side inserts gaps or stalls
  bit  no_idle = 1'b0;

  vector_lane_compress_expand u_top (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item (src_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // expected lane permutation for one vector
  function automatic res_item_t predict_lanes(input src_item_t it);
    logic [VECTOR_BITS-1:0] src;
    logic [VECTOR_BITS-1:0] dst;
    logic [VECTOR_BITS-1:0] lane_bits;
    logic [VECTOR_BITS-1:0] lane;
    int                     w;
    int                     count;
    int                     next;
    res_item_t              r;
    src       = {it.data_hi, it.data_lo};
    dst       = '0;
    w         = 8 << it.field_width_code;
    count     = VECTOR_BITS / w;
    next      = 0;
    lane_bits = {VECTOR_BITS{1'b1}} >> (VECTOR_BITS - w);
    for (int j = 0; j < count; j++) begin
      if (it.lane_mask[j]) begin
        if (it.func == FUNC_COMPRESS) begin
          // selected field j drops to the next free low field
          lane = (src >> (j * w)) & lane_bits;
          dst  = dst | (lane << (next * w));
        end else begin
          // next low source field lands in selected position j
          lane = (src >> (next * w)) & lane_bits;
          dst  = dst | (lane << (j * w));
        end
        next++;
      end
    end
    r.result_lo = dst[HALF_BITS-1:0];
    r.result_hi = dst[VECTOR_BITS-1:HALF_BITS];
    return r;
  endfunction

  // sends one vector item, with a random gap ahead of it
  task automatic drive_vector(input src_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= item;
    do @(posedge clk); while (!src_ready);
    // accepted at this edge
    lane_result_q.push_back(predict_lanes(item));
    items_sent++;
    width_sent[item.field_width_code]++;
    if (item.func == FUNC_COMPRESS) compress_sent++;
    else expand_sent++;
  endtask

  task automatic drive_fields(input func_t f, input field_width_t fw,
                              input logic [HALF_BITS-1:0] lo,
                              input logic [HALF_BITS-1:0] hi,
                              input logic [MASK_BITS-1:0] mask);
    src_item_t it;
    it.func             = f;
    it.field_width_code = fw;
    it.data_lo          = lo;
    it.data_hi          = hi;
    it.lane_mask        = mask;
    drive_vector(it);
  endtask

  task automatic wait_for_drain();
    while (lane_result_q.size() != 0) @(posedge clk);
  endtask

  // random mask, shaped so that empty, full, single and run masks are common
  function automatic logic [MASK_BITS-1:0] pick_mask();
    logic [MASK_BITS-1:0] m;
    int                   lo;
    int                   len;
    case ($urandom_range(0, 7))
      0: begin
        m = '0;
      end
      1: begin
        m = '1;
      end
      2: begin
        m = 16'h0001 << $urandom_range(0, MASK_BITS - 1);
      end
      3: begin
        // contiguous run of lanes
        lo  = $urandom_range(0, MASK_BITS - 1);
        len = $urandom_range(1, MASK_BITS - lo);
        m   = MASK_BITS'(((17'h1 << len) - 17'h1) << lo);
      end
      4: begin
        // dense: a few lanes cleared
        m = MASK_BITS'($urandom() | $urandom());
      end
      5: begin
        // sparse
        m = MASK_BITS'($urandom() & $urandom());
      end
      default: begin
        m = MASK_BITS'($urandom());
      end
    endcase
    return m;
  endfunction

  function automatic src_item_t pick_vector();
    src_item_t it;
    it.func             = func_t'($urandom_range(0, 1));
    it.field_width_code = field_width_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: begin
        it.data_lo = '1;
        it.data_hi = '1;
      end
      1: begin
        it.data_lo = '0;
        it.data_hi = '0;
      end
      default: begin
        it.data_lo = {$urandom(), $urandom()};
        it.data_hi = {$urandom(), $urandom()};
      end
    endcase
    it.lane_mask = pick_mask();
    return it;
  endfunction

  // result side: random stall ahead of every result item
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // result checker: compare each accepted item with the oldest prediction
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (lane_result_q.size() == 0) begin
        $error("unexpected result item: result_lo %h result_hi %h",
               res_item.result_lo, res_item.result_hi);
        error_count++;
      end else begin
        want = lane_result_q.pop_front();
        results_checked++;
        if (res_item.result_lo !== want.result_lo) begin
          $error("result_lo: expected %h, got %h", want.result_lo, res_item.result_lo);
          error_count++;
        end
        if (res_item.result_hi !== want.result_hi) begin
          $error("result_hi: expected %h, got %h", want.result_hi, res_item.result_hi);
          error_count++;
        end
      end
    end
  end

  // extremes of every width and operation: empty mask, full mask,
  // only lanes above the field count; alternating lanes at 8-bit width
  task automatic test_directed();
    field_width_t           fw;
    func_t                  f;
    int                     count;
    logic [MASK_BITS-1:0]   high_only;
    logic [HALF_BITS-1:0]   ramp_lo;
    logic [HALF_BITS-1:0]   ramp_hi;
    ramp_lo = 64'h0706050403020100;
    ramp_hi = 64'h0f0e0d0c0b0a0908;
    for (int c = 0; c < 4; c++) begin
      fw    = field_width_t'(c);
      count = VECTOR_BITS / (8 << c);
      // mask bits above the field count only (plus lane 0 for 8-bit fields)
      high_only = (count >= MASK_BITS) ? 16'h0001 : (16'hffff << count);
      for (int k = 0; k < 2; k++) begin
        f = func_t'(k);
        drive_fields(f, fw, '1, '1, '0);
        drive_fields(f, fw, ramp_lo, ramp_hi, '1);
        drive_fields(f, fw, ~ramp_lo, ~ramp_hi, high_only);
      end
    end
    drive_fields(FUNC_COMPRESS, FW_8, ramp_lo, ramp_hi, 16'haaaa);
    drive_fields(FUNC_EXPAND, FW_8, ramp_lo, ramp_hi, 16'h5555);
    drive_fields(FUNC_COMPRESS, FW_64, '0, '1, 16'h0002);
  endtask

  // random vectors, with stretches where neither side idles
  task automatic test_random();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 100) no_idle = 1'b1;
      if (n % 200 == 150) no_idle = 1'b0;
      drive_vector(pick_vector());
    end
    no_idle = 1'b0;
  endtask

  // sender holds off until the block has returned everything
  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) drive_vector(pick_vector());
    src_valid <= 1'b0;
    wait_for_drain();
    for (int n = 0; n < 20; n++) drive_vector(pick_vector());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random();
    src_valid <= 1'b0;
    wait_for_drain();
    // let any stray result show up
    repeat (20) @(posedge clk);
    if (lane_result_q.size() != 0) begin
      $error("%0d result items never arrived", lane_result_q.size());
      error_count++;
    end
    $display("sent %0d vectors (%0d compress, %0d expand), checked %0d results",
             items_sent, compress_sent, expand_sent, results_checked);
    $display("field widths 8/16/32/64: %0d/%0d/%0d/%0d items",
             width_sent[0], width_sent[1], width_sent[2], width_sent[3]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vlce_pkg.sv
hw/rtl/vlce_lane_map.sv
hw/rtl/vlce_permute.sv
hw/rtl/vector_lane_compress_expand.sv
verif/vector_lane_compress_expand_tb.sv
